/* rtl/core/dsn_pkg.sv */
// Shared types, constants and character codes for the DOS short-name normalizer.
`timescale 1ns / 1ps

package dsn_pkg;

    // Name limits
    localparam int BASE_CHARS  = 8;
    localparam int EXT_CHARS   = 3;
    localparam int INPUT_LIMIT = 19;

    // Field and counter widths
    localparam int BYTE_W     = 8;
    localparam int BASE_W     = 64;
    localparam int EXT_W      = 24;
    localparam int BASE_CNT_W = 4;
    localparam int EXT_CNT_W  = 2;
    localparam int SEEN_W     = 6;
    localparam int PEND_W     = 6;
    localparam int ROOM_W     = 7;

    typedef logic [BYTE_W-1:0]     byte_t;
    typedef logic [BASE_CNT_W-1:0] base_cnt_t;
    typedef logic [EXT_CNT_W-1:0]  ext_cnt_t;
    typedef logic [SEEN_W-1:0]     seen_t;
    typedef logic [PEND_W-1:0]     pend_t;
    typedef logic [ROOM_W-1:0]     room_t;

    // Character codes
    localparam byte_t CH_NUL        = 8'h00;
    localparam byte_t CH_TAB        = 8'h09;
    localparam byte_t CH_LF         = 8'h0A;
    localparam byte_t CH_CR         = 8'h0D;
    localparam byte_t CH_SPACE      = 8'h20;
    localparam byte_t CH_DOT        = 8'h2E;
    localparam byte_t CH_UNDERSCORE = 8'h5F;
    localparam byte_t CH_BACKQUOTE  = 8'h60;
    localparam byte_t CASE_OFFSET   = 8'h20;

    // Parse phase of the current name
    typedef enum logic [1:0] {
        PH_LEAD,
        PH_BASE,
        PH_EXT
    } phase_t;

    // Decoded view of one name byte
    typedef struct packed {
        logic  is_zero;
        logic  is_lead_blank;
        logic  is_blank;
        logic  is_space;
        logic  is_dot;
        logic  is_legal;
        byte_t upper;
    } byte_class_t;

    // One finished result
    typedef struct packed {
        logic              ok;
        logic [BASE_W-1:0] base_text;
        base_cnt_t         base_count;
        logic [EXT_W-1:0]  ext_text;
        ext_cnt_t          ext_count;
    } result_t;

endpackage

/* rtl/core/dos_short_name_normalizer.sv */
// Top level of the DOS 8.3 short-name normalizer: input and result registers.
`timescale 1ns / 1ps

// Takes a filename one byte per request, final_byte marking its last byte, and
// returns one result request per name: the upper-cased 8-character base and
// 3-character extension, packed first character in the low byte, their lengths
// and name_ok. The block accepts one byte every cycle; a byte is registered on
// entry, folded into the name state in one pass of per-byte logic, and a
// result is captured in the result register as its last byte is folded in.
// Only a full result register that is stalled holds back a last byte,
// and with it the input; other bytes keep flowing. There is no setup after
// reset.
module dos_short_name_normalizer
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [7:0]                  name_byte,
    input  logic                        final_byte,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        name_ok,
    output logic [63:0]                 base_text,
    output logic [3:0]                  base_count,
    output logic [23:0]                 ext_text,
    output logic [1:0]                  ext_count
);

    logic                 in_valid_reg, in_valid_next;
    dsn_pkg::byte_t       in_byte_reg;
    logic                 in_final_reg;
    logic                 out_valid_reg, out_valid_next;
    dsn_pkg::result_t     out_reg;
    dsn_pkg::byte_class_t cls;
    dsn_pkg::result_t     result;
    logic                 accept;
    logic                 fire;

    // Advance when the byte is not last or the result slot frees up
    always_comb
    begin
        fire     = in_valid_reg && (!in_final_reg || !out_valid_reg || !out_stall);
        in_stall = in_valid_reg && !fire;
        accept   = in_valid && !in_stall;
    end

    // Input and result valid flags
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (fire && in_final_reg)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the request and the finished result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg  <= name_byte;
            in_final_reg <= final_byte;
        end
        if (fire && in_final_reg)
            out_reg <= result;
    end

    dsn_classify u_classify
    (
        .name_byte (in_byte_reg),
        .cls       (cls)
    );

    dsn_accum u_accum
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .final_byte (in_final_reg),
        .cls        (cls),
        .result     (result)
    );

    // Drive the result ports
    assign out_valid  = out_valid_reg;
    assign name_ok    = out_reg.ok;
    assign base_text  = out_reg.base_text;
    assign base_count = out_reg.base_count;
    assign ext_text   = out_reg.ext_text;
    assign ext_count  = out_reg.ext_count;

`ifndef NO_ASSERTIONS
    a_reject_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.ok) |->
            (out_reg.base_count == '0) && (out_reg.ext_count == '0) &&
            (out_reg.base_text == '0) && (out_reg.ext_text == '0))
        else $error("rejected result carries name data");

    a_ok_has_base: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.ok) |-> (out_reg.base_count != '0))
        else $error("accepted result with empty base");

    a_no_result_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !(fire && in_final_reg))
        else $error("result overwritten while stalled");

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(fire && in_final_reg))
        else $error("result raised without a last byte");
`endif

endmodule

/* rtl/core/dsn_classify.sv */
// Byte decoder: blank, dot and legal-character classes plus upper-case fold.
`timescale 1ns / 1ps

module dsn_classify
(
    input  dsn_pkg::byte_t       name_byte,
    output dsn_pkg::byte_class_t cls
);

    // Check against the DOS short-name character set
    logic legal;

    always_comb
    begin
        case (name_byte) inside
            ["A":"Z"], ["a":"z"], ["0":"9"]:
                legal = 1'b1;
            "$", "%", "'", "-", "_", "@", "~", "!", "(", ")", "{", "}", "^", "#", "&",
            dsn_pkg::CH_BACKQUOTE:
                legal = 1'b1;
            default:
                legal = 1'b0;
        endcase
    end

    // Build the class word
    always_comb
    begin
        cls.is_zero       = (name_byte == dsn_pkg::CH_NUL);
        cls.is_space      = (name_byte == dsn_pkg::CH_SPACE);
        cls.is_lead_blank = (name_byte == dsn_pkg::CH_SPACE) ||
                            (name_byte == dsn_pkg::CH_TAB);
        cls.is_blank      = cls.is_lead_blank ||
                            (name_byte == dsn_pkg::CH_CR) ||
                            (name_byte == dsn_pkg::CH_LF);
        cls.is_dot        = (name_byte == dsn_pkg::CH_DOT);
        cls.is_legal      = legal;
        if ((name_byte >= "a") && (name_byte <= "z"))
            cls.upper = name_byte - dsn_pkg::CASE_OFFSET;
        else
            cls.upper = name_byte;
    end

endmodule

/* rtl/core/dsn_accum.sv */
// Per-name accumulator: parse phase, packed base/extension and result build.
`timescale 1ns / 1ps

module dsn_accum
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  logic                 final_byte,
    input  dsn_pkg::byte_class_t cls,
    output dsn_pkg::result_t     result
);

    dsn_pkg::phase_t       phase_reg, phase_next, phase_upd;
    logic [dsn_pkg::BASE_W-1:0] base_store_reg, base_store_next, base_store_upd;
    dsn_pkg::base_cnt_t    base_fill_reg, base_fill_next, base_fill_upd;
    logic [dsn_pkg::EXT_W-1:0]  ext_store_reg, ext_store_next, ext_store_upd;
    dsn_pkg::ext_cnt_t     ext_fill_reg, ext_fill_next, ext_fill_upd;
    dsn_pkg::pend_t        pend_reg, pend_next, pend_upd;
    logic                  pend_bad_reg, pend_bad_next, pend_bad_upd;
    logic                  rejected_reg, rejected_next, rejected_upd;
    dsn_pkg::seen_t        seen_reg, seen_next, seen_upd;
    logic                  ended_reg, ended_next, ended_upd;

    logic                  take;
    logic                  dropped;
    logic                  blank_step;
    logic                  char_step;
    logic                  to_ext;
    logic                  put;
    dsn_pkg::room_t        base_room, base_n;
    dsn_pkg::room_t        ext_room, ext_n;
    dsn_pkg::base_cnt_t    base_fill_flush;
    dsn_pkg::ext_cnt_t     ext_fill_flush;

    // Decide what this byte does
    always_comb
    begin
        take       = !ended_reg && (seen_reg < dsn_pkg::SEEN_W'(dsn_pkg::INPUT_LIMIT));
        dropped    = (phase_reg == dsn_pkg::PH_LEAD) && cls.is_lead_blank;
        blank_step = take && !cls.is_zero && !dropped && cls.is_blank;
        char_step  = take && !cls.is_zero && !dropped && !cls.is_blank;
        to_ext     = (phase_reg == dsn_pkg::PH_EXT);
        put        = cls.is_legal && !cls.is_dot;
    end

    // Size the flush of pending spaces against the room left
    always_comb
    begin
        base_room = dsn_pkg::room_t'(dsn_pkg::BASE_CHARS) - dsn_pkg::room_t'(base_fill_reg);
        base_n    = (dsn_pkg::room_t'(pend_reg) < base_room) ?
                    dsn_pkg::room_t'(pend_reg) : base_room;
        ext_room  = dsn_pkg::room_t'(dsn_pkg::EXT_CHARS) - dsn_pkg::room_t'(ext_fill_reg);
        ext_n     = (dsn_pkg::room_t'(pend_reg) < ext_room) ?
                    dsn_pkg::room_t'(pend_reg) : ext_room;
        base_fill_flush = base_fill_reg + base_n[dsn_pkg::BASE_CNT_W-1:0];
        ext_fill_flush  = ext_fill_reg + ext_n[dsn_pkg::EXT_CNT_W-1:0];
    end

    // Next phase
    always_comb
    begin
        phase_upd = phase_reg;
        if ((blank_step || char_step) && (phase_reg == dsn_pkg::PH_LEAD))
            phase_upd = dsn_pkg::PH_BASE;
        if (char_step && cls.is_dot && (phase_upd == dsn_pkg::PH_BASE))
            phase_upd = dsn_pkg::PH_EXT;

        if (!fire)
            phase_next = phase_reg;
        else if (final_byte)
            phase_next = dsn_pkg::PH_LEAD;
        else
            phase_next = phase_upd;
    end

    // Update stores, counters and flags
    always_comb
    begin
        base_store_upd = base_store_reg;
        base_fill_upd  = base_fill_reg;
        ext_store_upd  = ext_store_reg;
        ext_fill_upd   = ext_fill_reg;
        pend_upd       = pend_reg;
        pend_bad_upd   = pend_bad_reg;
        rejected_upd   = rejected_reg;
        seen_upd       = seen_reg;
        ended_upd      = ended_reg;

        if (take)
        begin
            seen_upd = seen_reg + 1'b1;
            if (cls.is_zero)
                ended_upd = 1'b1;
        end

        // Count a blank that may turn out to be inner
        if (blank_step)
        begin
            if (pend_reg != '1)
                pend_upd = pend_reg + 1'b1;
            if (!cls.is_space)
                pend_bad_upd = 1'b1;
        end

        // Flush pending blanks as underscores, then store the character
        if (char_step)
        begin
            pend_upd     = '0;
            pend_bad_upd = 1'b0;
            if (pend_bad_reg || (cls.is_dot && to_ext) || (!cls.is_dot && !cls.is_legal))
                rejected_upd = 1'b1;

            if (!to_ext)
            begin
                for (int i = 0; i < dsn_pkg::BASE_CHARS; i++)
                begin
                    if ((dsn_pkg::base_cnt_t'(i) >= base_fill_reg) &&
                        (dsn_pkg::base_cnt_t'(i) < base_fill_flush))
                        base_store_upd[8*i +: 8] = dsn_pkg::CH_UNDERSCORE;
                    else if (put && (dsn_pkg::base_cnt_t'(i) == base_fill_flush))
                        base_store_upd[8*i +: 8] = cls.upper;
                end
                base_fill_upd = base_fill_flush;
                if (put && (base_fill_flush < dsn_pkg::base_cnt_t'(dsn_pkg::BASE_CHARS)))
                    base_fill_upd = base_fill_flush + 1'b1;
            end
            else
            begin
                for (int i = 0; i < dsn_pkg::EXT_CHARS; i++)
                begin
                    if ((dsn_pkg::ext_cnt_t'(i) >= ext_fill_reg) &&
                        (dsn_pkg::ext_cnt_t'(i) < ext_fill_flush))
                        ext_store_upd[8*i +: 8] = dsn_pkg::CH_UNDERSCORE;
                    else if (put && (dsn_pkg::ext_cnt_t'(i) == ext_fill_flush))
                        ext_store_upd[8*i +: 8] = cls.upper;
                end
                ext_fill_upd = ext_fill_flush;
                if (put && (dsn_pkg::room_t'(ext_fill_flush) <
                            dsn_pkg::room_t'(dsn_pkg::EXT_CHARS)))
                    ext_fill_upd = ext_fill_flush + 1'b1;
            end
        end
    end

    // Hold, advance, or clear after the last byte
    always_comb
    begin
        base_store_next = base_store_reg;
        base_fill_next  = base_fill_reg;
        ext_store_next  = ext_store_reg;
        ext_fill_next   = ext_fill_reg;
        pend_next       = pend_reg;
        pend_bad_next   = pend_bad_reg;
        rejected_next   = rejected_reg;
        seen_next       = seen_reg;
        ended_next      = ended_reg;
        if (fire && final_byte)
        begin
            base_store_next = '0;
            base_fill_next  = '0;
            ext_store_next  = '0;
            ext_fill_next   = '0;
            pend_next       = '0;
            pend_bad_next   = 1'b0;
            rejected_next   = 1'b0;
            seen_next       = '0;
            ended_next      = 1'b0;
        end
        else if (fire)
        begin
            base_store_next = base_store_upd;
            base_fill_next  = base_fill_upd;
            ext_store_next  = ext_store_upd;
            ext_fill_next   = ext_fill_upd;
            pend_next       = pend_upd;
            pend_bad_next   = pend_bad_upd;
            rejected_next   = rejected_upd;
            seen_next       = seen_upd;
            ended_next      = ended_upd;
        end
    end

    // Build the result from the state after this byte
    always_comb
    begin
        result.ok         = !rejected_upd && (base_fill_upd != '0);
        result.base_text  = result.ok ? base_store_upd : '0;
        result.base_count = result.ok ? base_fill_upd : '0;
        result.ext_text   = result.ok ? ext_store_upd : '0;
        result.ext_count  = result.ok ? ext_fill_upd : '0;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= dsn_pkg::PH_LEAD;
            base_store_reg <= '0;
            base_fill_reg  <= '0;
            ext_store_reg  <= '0;
            ext_fill_reg   <= '0;
            pend_reg       <= '0;
            pend_bad_reg   <= 1'b0;
            rejected_reg   <= 1'b0;
            seen_reg       <= '0;
            ended_reg      <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            base_store_reg <= base_store_next;
            base_fill_reg  <= base_fill_next;
            ext_store_reg  <= ext_store_next;
            ext_fill_reg   <= ext_fill_next;
            pend_reg       <= pend_next;
            pend_bad_reg   <= pend_bad_next;
            rejected_reg   <= rejected_next;
            seen_reg       <= seen_next;
            ended_reg      <= ended_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_base_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        base_fill_reg <= dsn_pkg::base_cnt_t'(dsn_pkg::BASE_CHARS))
        else $error("base fill beyond limit");

    a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= dsn_pkg::SEEN_W'(dsn_pkg::INPUT_LIMIT))
        else $error("byte count beyond input limit");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && final_byte) |=> (phase_reg == dsn_pkg::PH_LEAD) &&
            (base_fill_reg == '0) && (ext_fill_reg == '0) && !rejected_reg &&
            (seen_reg == '0))
        else $error("state not cleared after last byte");

    a_ext_only_in_ext: assert property (@(posedge clk) disable iff (!rst_n)
        (ext_fill_reg != '0) |-> (phase_reg == dsn_pkg::PH_EXT))
        else $error("extension filled outside extension phase");
`endif

endmodule

/* tb/sv/dos_short_name_normalizer_test.sv */
// Self-checking testbench for the DOS 8.3 short-name normalizer.
`timescale 1ns / 1ps

module dos_short_name_normalizer_test;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  name_byte;
    logic        final_byte;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        name_ok;
    logic [63:0] base_text;
    logic [3:0]  base_count;
    logic [23:0] ext_text;
    logic [1:0]  ext_count;

    dos_short_name_normalizer dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .name_byte  (name_byte),
        .final_byte (final_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .name_ok    (name_ok),
        .base_text  (base_text),
        .base_count (base_count),
        .ext_text   (ext_text),
        .ext_count  (ext_count)
    );

    // Shadow copy of the name being parsed
    dsn_pkg::phase_t nm_phase;
    logic [63:0]     nm_base;
    int              nm_base_len;
    logic [23:0]     nm_ext;
    int              nm_ext_len;
    int              nm_pending;
    bit              nm_bad_blank;
    bit              nm_reject;
    int              nm_seen;
    bit              nm_ended;

    dsn_pkg::result_t expected_names[$];
    dsn_pkg::byte_t   name_buf[$];

    // Idling controls for sender and receiver
    bit          tx_gaps;
    bit          rx_gaps;
    int          hold_req;
    int          hold_left;
    int          stall_left;

    // Run statistics
    int          items_sent;
    int          names_sent;
    int          results_seen;
    int          rejects_seen;
    int          in_held;
    int          mismatches;

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // ---------------------------------------------------------------
    // Name predictor
    // ---------------------------------------------------------------

    function automatic bit is_dos_char(dsn_pkg::byte_t c);
        if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9"))
            return 1'b1;
        case (c)
            "$", "%", "'", "-", "_", "@", "~", "!", "(", ")", "{", "}", "^", "#", "&":
                return 1'b1;
            dsn_pkg::CH_BACKQUOTE:
                return 1'b1;
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic void clear_name();
        nm_phase     = dsn_pkg::PH_LEAD;
        nm_base      = '0;
        nm_base_len  = 0;
        nm_ext       = '0;
        nm_ext_len   = 0;
        nm_pending   = 0;
        nm_bad_blank = 1'b0;
        nm_reject    = 1'b0;
        nm_seen      = 0;
        nm_ended     = 1'b0;
    endfunction

    function automatic void store_char(dsn_pkg::byte_t c);
        if (nm_phase == dsn_pkg::PH_EXT)
        begin
            if (nm_ext_len < dsn_pkg::EXT_CHARS)
            begin
                nm_ext[8*nm_ext_len +: 8] = c;
                nm_ext_len++;
            end
        end
        else if (nm_base_len < dsn_pkg::BASE_CHARS)
        begin
            nm_base[8*nm_base_len +: 8] = c;
            nm_base_len++;
        end
    endfunction

    function automatic void fold_byte(dsn_pkg::byte_t b);
        bit blank;
        blank = (b == dsn_pkg::CH_SPACE || b == dsn_pkg::CH_TAB ||
                 b == dsn_pkg::CH_CR || b == dsn_pkg::CH_LF);
        if (b == dsn_pkg::CH_NUL)
        begin
            nm_ended = 1'b1;
            return;
        end
        // Drop leading space and tab only
        if (nm_phase == dsn_pkg::PH_LEAD && (b == dsn_pkg::CH_SPACE || b == dsn_pkg::CH_TAB))
            return;
        // Hold blanks until a non-blank shows they are inner
        if (blank)
        begin
            if (nm_phase == dsn_pkg::PH_LEAD)
                nm_phase = dsn_pkg::PH_BASE;
            if (nm_pending < 63)
                nm_pending++;
            if (b != dsn_pkg::CH_SPACE)
                nm_bad_blank = 1'b1;
            return;
        end
        if (nm_phase == dsn_pkg::PH_LEAD)
            nm_phase = dsn_pkg::PH_BASE;
        if (nm_bad_blank)
            nm_reject = 1'b1;
        repeat (nm_pending)
            store_char(dsn_pkg::CH_UNDERSCORE);
        nm_pending   = 0;
        nm_bad_blank = 1'b0;
        if (b == dsn_pkg::CH_DOT)
        begin
            if (nm_phase == dsn_pkg::PH_BASE)
                nm_phase = dsn_pkg::PH_EXT;
            else
                nm_reject = 1'b1;
        end
        else if (is_dos_char(b))
            store_char((b >= "a" && b <= "z") ? b - dsn_pkg::CASE_OFFSET : b);
        else
            nm_reject = 1'b1;
    endfunction

    function automatic void predict_item(dsn_pkg::byte_t b, bit last);
        dsn_pkg::result_t r;
        if (!nm_ended && nm_seen < dsn_pkg::INPUT_LIMIT)
        begin
            nm_seen++;
            fold_byte(b);
        end
        if (!last)
            return;
        r = '0;
        if (!nm_reject && nm_base_len > 0)
        begin
            r.ok         = 1'b1;
            r.base_text  = nm_base;
            r.base_count = dsn_pkg::base_cnt_t'(nm_base_len);
            r.ext_text   = nm_ext;
            r.ext_count  = dsn_pkg::ext_cnt_t'(nm_ext_len);
        end
        expected_names.push_back(r);
        clear_name();
    endfunction

    // ---------------------------------------------------------------
    // Idle lengths: mostly none or short, a few long
    // ---------------------------------------------------------------

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ---------------------------------------------------------------
    // Receiver: stall pattern and result check
    // ---------------------------------------------------------------

    always @(posedge clk)
    begin
        dsn_pkg::result_t got;
        dsn_pkg::result_t want;
        if (rst_n)
        begin
            if (in_valid && in_stall)
                in_held++;
            if (out_valid && !out_stall)
            begin
                got.ok         = name_ok;
                got.base_text  = base_text;
                got.base_count = base_count;
                got.ext_text   = ext_text;
                got.ext_count  = ext_count;
                results_seen++;
                if (got.ok !== 1'b1)
                    rejects_seen++;
                if (expected_names.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with nothing expected: ok=%b base=%h/%0d ext=%h/%0d",
                                 $realtime, got.ok, got.base_text, got.base_count,
                                 got.ext_text, got.ext_count);
                end
                else
                begin
                    want = expected_names.pop_front();
                    if (got.ok !== want.ok || got.base_text !== want.base_text ||
                        got.base_count !== want.base_count ||
                        got.ext_text !== want.ext_text || got.ext_count !== want.ext_count)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: name result mismatch", $realtime);
                            $display("  expected ok=%b base=%h/%0d ext=%h/%0d", want.ok,
                                     want.base_text, want.base_count, want.ext_text,
                                     want.ext_count);
                            $display("  actual   ok=%b base=%h/%0d ext=%h/%0d", got.ok,
                                     got.base_text, got.base_count, got.ext_text,
                                     got.ext_count);
                        end
                    end
                end
            end
        end

        // Pick up a long hold-off request, then count it down
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (rx_gaps && stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
            if (rx_gaps && $urandom_range(0, 3) == 0)
                stall_left = idle_len();
        end
    end

    // ---------------------------------------------------------------
    // Sender
    // ---------------------------------------------------------------

    task automatic send_byte(dsn_pkg::byte_t b, bit last);
        int gap;
        in_valid   <= 1'b1;
        name_byte  <= b;
        final_byte <= last;
        do
            @(posedge clk);
        while (in_stall);
        predict_item(b, last);
        items_sent++;
        gap = tx_gaps ? idle_len() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_name();
        foreach (name_buf[i])
            send_byte(name_buf[i], i == name_buf.size() - 1);
        names_sent++;
    endtask

    // Pause the sender until every expected result has come back or the limit runs out
    task automatic drain_results(int limit);
        int n;
        n = 0;
        in_valid <= 1'b0;
        while (expected_names.size() != 0 && n < limit)
        begin
            @(posedge clk);
            n++;
        end
        repeat (8) @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // Name builders
    // ---------------------------------------------------------------

    function automatic void load_text(string s);
        name_buf.delete();
        for (int i = 0; i < s.len(); i++)
            name_buf.push_back(dsn_pkg::byte_t'(s[i]));
    endfunction

    function automatic dsn_pkg::byte_t pick_legal();
        dsn_pkg::byte_t c;
        do
            c = dsn_pkg::byte_t'($urandom_range(33, 126));
        while (!is_dos_char(c));
        return c;
    endfunction

    function automatic dsn_pkg::byte_t pick_blank();
        case ($urandom_range(0, 3))
            0:       return dsn_pkg::CH_SPACE;
            1:       return dsn_pkg::CH_TAB;
            2:       return dsn_pkg::CH_CR;
            default: return dsn_pkg::CH_LF;
        endcase
    endfunction

    // Leading blanks, base with the odd inner space, optional dot part, trailing blanks
    function automatic void build_wellformed();
        int n;
        name_buf.delete();
        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 3))
                name_buf.push_back($urandom_range(0, 1) ? dsn_pkg::CH_SPACE : dsn_pkg::CH_TAB);
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
        begin
            if (i > 0 && i < n - 1 && $urandom_range(0, 11) == 0)
                name_buf.push_back(dsn_pkg::CH_SPACE);
            else
                name_buf.push_back(pick_legal());
        end
        if ($urandom_range(0, 3) != 0)
        begin
            name_buf.push_back(dsn_pkg::CH_DOT);
            repeat ($urandom_range(0, 4))
                name_buf.push_back(pick_legal());
        end
        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 2))
                name_buf.push_back(pick_blank());
    endfunction

    // Well-formed name with one byte spoiled
    function automatic void build_broken();
        dsn_pkg::byte_t bad;
        int             pos;
        build_wellformed();
        case ($urandom_range(0, 9))
            0:       bad = dsn_pkg::CH_NUL;
            1:       bad = dsn_pkg::CH_DOT;
            2:       bad = "\\";
            3:       bad = "/";
            4:       bad = ":";
            5:       bad = pick_blank();
            6:       bad = dsn_pkg::byte_t'($urandom_range(128, 255));
            default: bad = dsn_pkg::byte_t'($urandom_range(0, 255));
        endcase
        pos = $urandom_range(0, name_buf.size());
        if ($urandom_range(0, 1) && pos < name_buf.size())
            name_buf[pos] = bad;
        else
            name_buf.insert(pos, bad);
    endfunction

    function automatic void build_noise();
        name_buf.delete();
        repeat ($urandom_range(1, 24))
            name_buf.push_back(dsn_pkg::byte_t'($urandom_range(0, 255)));
    endfunction

    // Names that run past the input limit
    function automatic void build_long();
        int n;
        build_wellformed();
        n = $urandom_range(dsn_pkg::INPUT_LIMIT + 1, dsn_pkg::INPUT_LIMIT + 12);
        while (name_buf.size() < n)
            name_buf.push_back(($urandom_range(0, 5) == 0) ? pick_blank() : pick_legal());
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Special cases, one short name each
    task automatic test_directed();
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        name_buf = {dsn_pkg::CH_NUL};           // empty name
        send_name();
        load_text(".");                         // no base
        send_name();
        load_text(" \ta b.c ");                 // leading, inner and trailing blanks
        send_name();
        load_text("z~");                        // leading LF counts as an inner blank
        name_buf.push_front(dsn_pkg::CH_LF);
        send_name();
        load_text("a..");                       // second dot
        send_name();
        name_buf = {8'hFF};                     // high byte
        send_name();
        load_text(":");
        send_name();
        load_text("\\");
        send_name();
        load_text("a.");                        // empty extension, trailing CR
        name_buf.push_back(dsn_pkg::CH_CR);
        send_name();
        name_buf = {"a", dsn_pkg::CH_NUL, "/"}; // bytes after a zero are ignored
        send_name();
        drain_results(500);
    endtask

    // Random mix, idling on both sides
    task automatic test_mixed_names(int n_items);
        int stop_at;
        int kind;
        stop_at = items_sent + n_items;
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        while (items_sent < stop_at)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 6)
                build_wellformed();
            else if (kind < 8)
                build_broken();
            else if (kind < 9)
                build_noise();
            else
                build_long();
            send_name();
        end
    endtask

    // Overlong base, extension and whole names
    task automatic test_overlong_names(int n_items);
        int stop_at;
        stop_at = items_sent + n_items;
        tx_gaps = 1'b1;
        rx_gaps = 1'b0;
        while (items_sent < stop_at)
        begin
            build_long();
            send_name();
        end
    endtask

    // Full rate, no idling anywhere
    task automatic test_back_to_back(int n_items);
        int stop_at;
        stop_at = items_sent + n_items;
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 3) == 0)
                build_broken();
            else
                build_wellformed();
            send_name();
        end
    endtask

    // Long receiver hold-off against a stream of short names
    task automatic test_result_backlog(int n_items);
        int stop_at;
        stop_at = items_sent + n_items;
        tx_gaps  = 1'b0;
        rx_gaps  = 1'b0;
        hold_req = 120;
        while (items_sent < stop_at)
        begin
            name_buf.delete();
            repeat ($urandom_range(1, 2))
                name_buf.push_back(pick_legal());
            send_name();
        end
        drain_results(2000);
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        name_byte  = '0;
        final_byte = 1'b0;
        tx_gaps    = 1'b0;
        rx_gaps    = 1'b0;
        hold_req   = 0;
        hold_left  = 0;
        stall_left = 0;
        clear_name();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_mixed_names(550);
        test_result_backlog(100);
        test_overlong_names(160);
        test_back_to_back(200);
        test_mixed_names(80);

        drain_results(4000);
        if (expected_names.size() != 0)
        begin
            mismatches++;
            $display("%0d expected results never arrived", expected_names.size());
        end
        $display("Sent %0d bytes in %0d names; checked %0d results, %0d of them rejected.",
                 items_sent, names_sent, results_seen, rejects_seen);
        $display("Input was held back on %0d cycles; %0d mismatches.", in_held, mismatches);
        if (mismatches == 0)
            $display("** dos_short_name_normalizer: PASSED **");
        else
            $display("** dos_short_name_normalizer: FAILED **");
        $finish;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #3000000;
        $display("Timed out with %0d results outstanding", expected_names.size());
        $display("** dos_short_name_normalizer: FAILED **");
        $finish;
    end

endmodule

/* files.f */
rtl/core/dsn_pkg.sv
rtl/core/dsn_classify.sv
rtl/core/dsn_accum.sv
rtl/core/dos_short_name_normalizer.sv
tb/sv/dos_short_name_normalizer_test.sv
